>>> rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants for the FIFO page replacement block
// Holds the default sizes, the probe and cell control structs, the state
// encoding and the configuration reset and counter constants.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int unsigned ENTRIES_DEFAULT   = 16;
    localparam int unsigned PAGE_BITS_DEFAULT = 32;

    localparam int unsigned CFG_W    = 5;
    localparam int unsigned COUNT_W  = 32;

    localparam logic [CFG_W-1:0]   ACTIVE_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    // Control bits that travel with a request down the cell row
    typedef struct packed {
        logic vld;
        logic hit;
    } t_probe;

    // Per-cell control from the top level
    typedef struct packed {
        logic enable;
        logic wr_en;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

>>> rtl/fifo_page_replacement.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement: fully associative page store, FIFO replacement
// Looks up each requested page in a row of slots and replaces the oldest
// slot on a miss, reporting hit/miss with saturating miss and request counts.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive i_page_number and pulse start while busy is low; the
//   item is taken at that edge and busy stays high until it is finished.
//   Result: o_result_valid is high for one cycle with o_hit, o_miss_count
//   and o_request_count; the receiver cannot hold it off.
//   Configuration: i_cfg_valid/o_cfg_ready write active_entries (1..ENTRIES,
//   0 acts as 1, larger values act as ENTRIES); write it only while idle.
// Operation:
//   The request walks the row of ENTRIES cells, one cell per cycle starting
//   in the accepting cycle; as it leaves the last cell, the store and
//   counters are updated and the result is registered. A new request can
//   be taken at the edge that ends the result cycle, so the block takes no
//   new request while one is still in the row or being finished.
// Reset:
//   Synchronous, active low. Clears all valid bits, the fill pointer and
//   both counters, and sets active_entries to 16. No clearing pass.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
    parameter int unsigned ENTRIES   = fpr_pkg::ENTRIES_DEFAULT,
    parameter int unsigned PAGE_BITS = fpr_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [PAGE_BITS-1:0]         i_page_number,
    output logic                         o_result_valid,
    output logic                         o_hit,
    output logic [fpr_pkg::COUNT_W-1:0]  o_miss_count,
    output logic [fpr_pkg::COUNT_W-1:0]  o_request_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fpr_pkg::CFG_W-1:0]    i_cfg_active_entries
);
    import fpr_pkg::*;

    localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
    localparam int unsigned SLOT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state               r_state;
    t_state               n_state;
    logic [CFG_W-1:0]     r_active;
    logic [IDX_W-1:0]     r_fill;
    logic [IDX_W-1:0]     n_fill;
    logic [COUNT_W-1:0]   r_misses;
    logic [COUNT_W-1:0]   n_misses;
    logic [COUNT_W-1:0]   r_requests;
    logic [COUNT_W-1:0]   n_requests;
    logic                 r_result_valid;
    logic                 r_hit;

    t_probe               w_probe [0:ENTRIES];
    logic [PAGE_BITS-1:0] w_page  [0:ENTRIES];
    t_cell_ctrl           w_ctrl  [0:ENTRIES-1];
    logic [ENTRIES-1:0]   w_probe_vld;

    logic                 w_accept;
    logic                 w_finish;
    logic                 w_write;
    logic [SLOT_W-1:0]    w_cfg_ext;
    logic [SLOT_W-1:0]    w_slots;
    logic [SLOT_W-1:0]    w_at_ext;
    logic [SLOT_W-1:0]    w_next_ext;
    logic [IDX_W-1:0]     w_at;

    // Clamp the active entry count to 1..ENTRIES
    assign w_cfg_ext = SLOT_W'(r_active);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_slots = SLOT_W'(1);
        end else if (w_cfg_ext > SLOT_W'(ENTRIES)) begin
            w_slots = SLOT_W'(ENTRIES);
        end else begin
            w_slots = w_cfg_ext;
        end
    end

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_active_entries;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_probe[ENTRIES].vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy     = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                busy     = 1'b1;
                w_finish = w_probe[ENTRIES].vld;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_accept = start && !busy;

    // Inject the request at the head of the row
    assign w_probe[0] = t_probe'{vld: w_accept, hit: 1'b0};
    assign w_page[0]  = i_page_number;

    // Replacement slot: wrap to zero if the pointer left the active range
    assign w_at_ext   = (SLOT_W'(r_fill) < w_slots) ? SLOT_W'(r_fill) : '0;
    assign w_at       = w_at_ext[IDX_W-1:0];
    assign w_next_ext = w_at_ext + SLOT_W'(1);
    assign n_fill     = (w_next_ext >= w_slots) ? '0 : w_next_ext[IDX_W-1:0];
    assign w_write    = w_finish && !w_probe[ENTRIES].hit;

    // Row of cells
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        always_comb begin
            w_ctrl[k].enable = (SLOT_W'(k) < w_slots);
            w_ctrl[k].wr_en  = w_write && (w_at == IDX_W'(k));
        end
        assign w_probe_vld[k] = w_probe[k+1].vld;

        fpr_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_probe   (w_probe[k]),
            .i_page    (w_page[k]),
            .i_ctrl    (w_ctrl[k]),
            .i_wr_page (w_page[ENTRIES]),
            .o_probe   (w_probe[k+1]),
            .o_page    (w_page[k+1])
        );
    end

    // Saturating counters
    always_comb begin
        n_misses   = r_misses;
        n_requests = r_requests;
        if (w_write && (r_misses != COUNT_MAX)) begin
            n_misses = r_misses + COUNT_W'(1);
        end
        if (w_finish && (r_requests != COUNT_MAX)) begin
            n_requests = r_requests + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill         <= '0;
            r_misses       <= '0;
            r_requests     <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_misses       <= n_misses;
            r_requests     <= n_requests;
            r_result_valid <= w_finish;
            if (w_write) begin
                r_fill <= n_fill;
            end
        end
    end

    // Hold the hit flag of the finished item
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_hit <= w_probe[ENTRIES].hit;
        end
    end

    assign o_result_valid  = r_result_valid;
    assign o_hit           = r_hit;
    assign o_miss_count    = r_misses;
    assign o_request_count = r_requests;

    // Checks
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_probe_vld) <= 1)
        else $error("more than one item in the cell row");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without an item in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted item did not raise busy");

    a_counts_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_miss_count <= o_request_count))
        else $error("miss count exceeds request count");

endmodule

>>> rtl/fpr_cell.sv
// ----------------------------------------------------------------------------
// fpr_cell: one page slot of the replacement row
// Stores one page and its valid bit, compares the passing request against
// it and hands the request with its running hit flag to the next cell.
// ----------------------------------------------------------------------------
module fpr_cell #(
    parameter int unsigned PAGE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpr_pkg::t_probe       i_probe,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  fpr_pkg::t_cell_ctrl   i_ctrl,
    input  logic [PAGE_BITS-1:0]  i_wr_page,
    output fpr_pkg::t_probe       o_probe,
    output logic [PAGE_BITS-1:0]  o_page
);
    import fpr_pkg::*;

    logic [PAGE_BITS-1:0] r_store;
    logic                 r_valid;
    t_probe               r_probe;
    t_probe               n_probe;
    logic [PAGE_BITS-1:0] r_page;
    logic                 w_match;

    // Compare only while the slot is valid and inside the active range
    assign w_match = r_valid && i_ctrl.enable && (r_store == i_page);

    always_comb begin
        n_probe.vld = i_probe.vld;
        n_probe.hit = i_probe.hit | w_match;
    end

    // Advance the request to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= i_page;
    end

    // Fill the slot on a miss aimed here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.wr_en) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_store <= i_wr_page;
        end
    end

    assign o_probe = r_probe;
    assign o_page  = r_page;

endmodule

>>> tb/tb_fifo_page_replacement.sv
// ----------------------------------------------------------------------------
// tb_fifo_page_replacement: self-checking bench for the FIFO page store
// Drives page requests through the start/busy handshake, predicts hit/miss,
// the fill position and the running counts, and checks every result strobe
// in order. Runs a directed pass over the corner cases, then random traffic
// from a small reused page pool under several active-entry settings.
// ----------------------------------------------------------------------------
module tb_fifo_page_replacement;

    import fpr_pkg::*;

    localparam int unsigned ENTRIES      = ENTRIES_DEFAULT;
    localparam int unsigned PAGE_BITS    = PAGE_BITS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
    localparam int unsigned POOL_SIZE    = 32;
    localparam int unsigned NUM_PHASES   = 12;
    localparam int unsigned PHASE_ITEMS  = 128;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] misses;
        logic [COUNT_W-1:0] requests;
    } t_lookup_result;

    // Predict the page store and hold the results still owed by the block
    class replacement_tracker;
        logic [PAGE_BITS-1:0] pages [ENTRIES];
        bit   [ENTRIES-1:0]   valid;
        int unsigned          fill_ptr;
        logic [COUNT_W-1:0]   misses;
        logic [COUNT_W-1:0]   requests;
        logic [CFG_W-1:0]     active;
        t_lookup_result       owed_results[$];
        int unsigned          mismatches;
        int unsigned          hits_seen;
        int unsigned          misses_seen;

        function new();
            foreach (pages[i]) pages[i] = '0;
            valid       = '0;
            fill_ptr    = 0;
            misses      = '0;
            requests    = '0;
            active      = ACTIVE_RESET;
            mismatches  = 0;
            hits_seen   = 0;
            misses_seen = 0;
        endfunction

        function void set_active(logic [CFG_W-1:0] value);
            active = value;
        endfunction

        // Zero acts as one, anything above the built size acts as the size
        function int unsigned slots_in_use();
            if (active == 0) return 1;
            if (active > ENTRIES) return ENTRIES;
            return active;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Look up one accepted page, update the store and queue its result
        function void note_request(logic [PAGE_BITS-1:0] page);
            int unsigned    slots;
            int unsigned    at;
            bit             found;
            t_lookup_result res;
            slots = slots_in_use();
            found = 1'b0;
            for (int i = 0; i < slots; i++) begin
                if (valid[i] && pages[i] == page) found = 1'b1;
            end
            if (!found) begin
                // A pointer left past a lowered count restarts at entry zero
                at        = (fill_ptr < slots) ? fill_ptr : 0;
                pages[at] = page;
                valid[at] = 1'b1;
                at++;
                fill_ptr  = (at >= slots) ? 0 : at;
                if (misses != COUNT_MAX) misses++;
            end
            if (requests != COUNT_MAX) requests++;
            res.hit      = found;
            res.misses   = misses;
            res.requests = requests;
            owed_results.push_back(res);
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        // Compare one result strobe with the oldest owed result
        task check_result(logic hit, logic [COUNT_W-1:0] miss_cnt,
                          logic [COUNT_W-1:0] req_cnt);
            t_lookup_result want;
            if (owed_results.size() == 0) begin
                report($sformatf("result with nothing owed: hit=%0b requests=%0d",
                                 hit, req_cnt));
                return;
            end
            want = owed_results.pop_front();
            if (want.hit) hits_seen++;
            else misses_seen++;
            if (hit !== want.hit)
                report($sformatf("request %0d hit: got %0b want %0b",
                                 want.requests, hit, want.hit));
            if (miss_cnt !== want.misses)
                report($sformatf("request %0d miss_count: got %0d want %0d",
                                 want.requests, miss_cnt, want.misses));
            if (req_cnt !== want.requests)
                report($sformatf("request_count: got %0d want %0d",
                                 req_cnt, want.requests));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [PAGE_BITS-1:0] i_page_number;
    logic                 o_result_valid;
    logic                 o_hit;
    logic [COUNT_W-1:0]   o_miss_count;
    logic [COUNT_W-1:0]   o_request_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_active_entries;

    replacement_tracker   board;
    int unsigned          idle_pct;
    int unsigned          requests_sent;
    int unsigned          settings_used;
    int unsigned          cycle_count = 0;
    logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

    fifo_page_replacement #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_page_number        (i_page_number),
        .o_result_valid       (o_result_valid),
        .o_hit                (o_hit),
        .o_miss_count         (o_miss_count),
        .o_request_count      (o_request_count),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_active_entries (i_cfg_active_entries)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every result strobe at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && board != null)
            board.check_result(o_hit, o_miss_count, o_request_count);
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results owed",
                     cycle_count, board.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one page, idling at random first; return at the accepting edge
    task automatic issue_page(input logic [PAGE_BITS-1:0] page);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (busy);
        board.note_request(page);
        requests_sent++;
    endtask

    // Drain the block, then write the active entry count
    task automatic write_active(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0 || busy) @(negedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_active_entries <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_active(value);
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly reuse pool pages so hits and evictions happen; sometimes go wide
    function automatic logic [PAGE_BITS-1:0] pick_page();
        int unsigned span;
        span = board.slots_in_use() + $urandom_range(1, 6);
        if ($urandom_range(0, 99) < 85)
            return page_pool[$urandom_range(0, span - 1)];
        return $urandom();
    endfunction

    logic [CFG_W-1:0] phase_active [NUM_PHASES] =
        '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd8, 5'd3, 5'd12, 5'd2, 5'd15, 5'd16};
    int unsigned      phase_idle [4] = '{0, 69, 0, 34};

    initial begin
        board                = new();
        idle_pct             = 0;
        requests_sent        = 0;
        settings_used        = 0;
        i_rst_n              = 1'b0;
        start                = 1'b0;
        i_page_number        = '0;
        i_cfg_valid          = 1'b0;
        i_cfg_active_entries = ACTIVE_RESET;
        foreach (page_pool[i]) page_pool[i] = $urandom();
        page_pool[0] = '0;
        page_pool[1] = '1;

        // Hold reset low before releasing it
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all-ones and zero pages must miss on an empty store
        issue_page('1);
        issue_page('0);
        issue_page('1);
        issue_page('0);
        issue_page(32'hAAAA_AAAA);
        issue_page(32'h5555_5555);

        // Lower the count below the fill pointer; entries above it go dark
        write_active(5'd2);
        issue_page(32'h1234_5678);
        issue_page('1);
        issue_page(32'hAAAA_AAAA);
        issue_page('1);

        // Raise it again: dark entries take part with their old contents
        write_active(5'd16);
        issue_page(32'h5555_5555);
        issue_page('0);

        // Zero behaves as one slot
        write_active(5'd0);
        issue_page(32'hAAAA_AAAA);
        issue_page(32'h5555_5555);
        issue_page(32'h5555_5555);

        // Above the built size clamps to the full store
        write_active(5'd31);
        issue_page(32'h8000_0001);
        issue_page(32'hAAAA_AAAA);
        issue_page(32'h7FFF_FFFE);

        // Random traffic over the settings, cycling the idle mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_active(phase_active[p]);
            idle_pct = phase_idle[p % 4];
            for (int k = 0; k < 4; k++)
                page_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue_page(pick_page());
        end

        // Drop start and wait out the last results
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d page requests over %0d count writes: %0d hits, %0d misses checked",
                 requests_sent, settings_used, board.hits_seen, board.misses_seen);
        $display("Counts covered zero, one, mid, full and clamped sizes; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> fifo_page_replacement.f
rtl/fpr_pkg.sv
rtl/fpr_cell.sv
rtl/fifo_page_replacement.sv
tb/tb_fifo_page_replacement.sv
